>>> design/rapc_pkg.sv
// Package: shared types, codes and constants of the relay actuator position control.
`default_nettype none

package rapc_pkg;

    localparam int unsigned LEN_W   = 16;
    localparam int unsigned TURN_W  = 12;
    localparam int unsigned DB_W    = 8;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned PROD_W  = 32;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned CIDX_W  = 3;

    // Pulses that come this many milliseconds or less after the last one are dropped.
    localparam logic [TIME_W-1:0] DEBOUNCE_MS  = 32'd10;
    // 100.00 percent in 0.01 percent units.
    localparam logic [LEN_W-1:0]  PERCENT_FULL = 16'd10000;
    localparam logic [TURN_W-1:0] TURN_MAX     = 12'd4095;
    localparam logic [LEN_W-1:0]  TARGET_MAX   = 16'hFFFF;

    // Division by 10000 is a shift right by four followed by a division by 625, done as a
    // multiply by the rounded-up reciprocal of 625 scaled by 2^38. That is exact for every
    // 28-bit numerator.
    localparam int unsigned PCT_PRE_SHIFT   = 4;
    localparam int unsigned PCT_RECIP_W     = 29;
    localparam int unsigned PCT_RECIP_SHIFT = 38;
    localparam logic [PCT_RECIP_W-1:0] PCT_RECIP = 29'd439804652;

    // Register indexes on the configuration port.
    localparam logic [CIDX_W-1:0] CFG_TOTAL_LENGTH   = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_USED_LENGTH    = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_MAX_TURNS      = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_TURN_DEADBAND  = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_CALIBRATION_MS = 3'd4;

    // Register values after reset.
    localparam logic [LEN_W-1:0]  RST_TOTAL_LENGTH   = 16'd10000;
    localparam logic [LEN_W-1:0]  RST_USED_LENGTH    = 16'd10000;
    localparam logic [TURN_W-1:0] RST_MAX_TURNS      = 12'd100;
    localparam logic [DB_W-1:0]   RST_TURN_DEADBAND  = 8'd1;
    localparam logic [LEN_W-1:0]  RST_CALIBRATION_MS = 16'd10000;

    typedef enum logic [2:0] {
        ACT_TICK        = 3'd0,
        ACT_PULSE       = 3'd1,
        ACT_SET_LENGTH  = 3'd2,
        ACT_SET_PERCENT = 3'd3,
        ACT_CALIBRATE   = 3'd4,
        ACT_SET_TURNS   = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        DRIVE_STOP    = 2'd0,
        DRIVE_EXTEND  = 2'd1,
        DRIVE_RETRACT = 2'd2
    } drive_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MULT,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_COMMIT
    } fsm_state_t;

    typedef struct packed {
        logic [2:0]       action;
        logic [LEN_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        drive_state;
        logic              extend_relay_level;
        logic              retract_relay_level;
        logic [TURN_W-1:0] current_turns;
        logic [LEN_W-1:0]  target_turns;
        logic              calibrating;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic mul_go;
        logic div_start;
        logic commit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic needs_div;
        logic div_done;
    } status_t;

endpackage

`default_nettype wire

>>> design/rapc_div.sv
// Restoring divider: 32-bit dividend by 16-bit divisor, one quotient bit per cycle.
`default_nettype none

module rapc_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [rapc_pkg::PROD_W-1:0]   dividend,
    input  wire logic [rapc_pkg::LEN_W-1:0]    divisor,
    output logic      [rapc_pkg::PROD_W-1:0]   quotient,
    output logic                               done
);

    localparam int unsigned CNT_W = $clog2(rapc_pkg::PROD_W);

    logic [rapc_pkg::PROD_W-1:0] quo_reg, quo_next;
    logic [rapc_pkg::LEN_W-1:0]  rem_reg, rem_next;
    logic [rapc_pkg::LEN_W-1:0]  dvs_reg;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [rapc_pkg::LEN_W:0]    shifted;
    logic [rapc_pkg::LEN_W:0]    diff;
    logic                        q_bit;

    // The dividend shifts out of the top of the quotient register as quotient bits enter below.
    always_comb begin
        shifted = {rem_reg, quo_reg[rapc_pkg::PROD_W-1]};
        diff    = shifted - {1'b0, dvs_reg};
        q_bit   = (shifted >= {1'b0, dvs_reg});
        rem_next = q_bit ? diff[rapc_pkg::LEN_W-1:0] : shifted[rapc_pkg::LEN_W-1:0];
        quo_next = {quo_reg[rapc_pkg::PROD_W-2:0], q_bit};
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(rapc_pkg::PROD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

>>> design/rapc_ctrl.sv
// Controller: sequences one item through decode, multiply, divide and commit.
`default_nettype none

module rapc_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    input  wire rapc_pkg::status_t status,
    output rapc_pkg::cmd_t         cmd
);

    rapc_pkg::fsm_state_t state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rapc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            rapc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = rapc_pkg::ST_DECODE;
                end
            end
            rapc_pkg::ST_DECODE: begin
                state_next = status.needs_div ? rapc_pkg::ST_MULT : rapc_pkg::ST_COMMIT;
            end
            rapc_pkg::ST_MULT: begin
                cmd.mul_go = 1'b1;
                state_next = rapc_pkg::ST_DIV_LOAD;
            end
            rapc_pkg::ST_DIV_LOAD: begin
                cmd.div_start = 1'b1;
                state_next    = rapc_pkg::ST_DIV_RUN;
            end
            rapc_pkg::ST_DIV_RUN: begin
                if (status.div_done) begin
                    state_next = rapc_pkg::ST_COMMIT;
                end
            end
            rapc_pkg::ST_COMMIT: begin
                // The state registers double as the result register, so they change
                // only once the previous result has left.
                if (!out_valid_reg || m_ready) begin
                    cmd.commit = 1'b1;
                    state_next = rapc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rapc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> design/rapc_dp.sv
// Datapath: configuration, control state, multiplier and divider of the position control.
`default_nettype none

module rapc_dp (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [rapc_pkg::CIDX_W-1:0]  cfg_index,
    input  wire logic [rapc_pkg::CFG_W-1:0]   cfg_data,
    input  wire rapc_pkg::in_item_t           s_data,
    output rapc_pkg::out_item_t               m_data,
    input  wire rapc_pkg::cmd_t               cmd,
    output rapc_pkg::status_t                 status
);

    localparam int unsigned LEN_W   = rapc_pkg::LEN_W;
    localparam int unsigned TURN_W  = rapc_pkg::TURN_W;
    localparam int unsigned TIME_W  = rapc_pkg::TIME_W;
    localparam int unsigned PROD_W  = rapc_pkg::PROD_W;
    localparam int unsigned DB_W    = rapc_pkg::DB_W;
    localparam int unsigned PCT_N_W = PROD_W - rapc_pkg::PCT_PRE_SHIFT;
    localparam int unsigned PCT_P_W = PCT_N_W + rapc_pkg::PCT_RECIP_W;

    // Configuration registers.
    logic [LEN_W-1:0]  total_length_reg;
    logic [LEN_W-1:0]  used_length_reg;
    logic [TURN_W-1:0] max_turns_reg;
    logic [DB_W-1:0]   turn_deadband_reg;
    logic [LEN_W-1:0]  calibration_ms_reg;

    // Control state.
    logic [TIME_W-1:0]  time_reg, time_next;
    logic [TIME_W-1:0]  last_pulse_reg, last_pulse_next;
    logic [TIME_W-1:0]  cal_start_reg, cal_start_next;
    logic               cal_reg, cal_next;
    rapc_pkg::drive_t   mode_reg, mode_next;
    logic [TURN_W-1:0]  turns_reg, turns_next;
    logic [LEN_W-1:0]   req_len_reg, req_len_next;
    logic [LEN_W-1:0]   target_reg, target_next;

    // Item being worked on and arithmetic.
    logic [2:0]         action_reg;
    logic [LEN_W-1:0]   value_reg;
    logic [PROD_W-1:0]  product_reg;
    logic [LEN_W-1:0]   mul_a, mul_b;
    logic [PROD_W-1:0]  quotient;
    logic               div_done;
    logic               div_start;
    rapc_pkg::action_t  action;

    // Percent path: constant division by reciprocal multiplication.
    logic [PCT_N_W-1:0] pct_num;
    logic [PCT_P_W-1:0] pct_prod;
    logic [PROD_W-1:0]  pct_quo_reg;
    logic               pct_done_reg;

    logic [TIME_W-1:0]  tick_time;
    logic [TIME_W-1:0]  cal_elapsed;
    logic [TIME_W-1:0]  pulse_gap;
    logic [TURN_W:0]    turns_step;
    logic [LEN_W-1:0]   target_sat;
    logic [LEN_W-1:0]   turns_wide;
    logic [LEN_W-1:0]   quo_low;

    assign action = rapc_pkg::action_t'(action_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_length_reg   <= rapc_pkg::RST_TOTAL_LENGTH;
            used_length_reg    <= rapc_pkg::RST_USED_LENGTH;
            max_turns_reg      <= rapc_pkg::RST_MAX_TURNS;
            turn_deadband_reg  <= rapc_pkg::RST_TURN_DEADBAND;
            calibration_ms_reg <= rapc_pkg::RST_CALIBRATION_MS;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                rapc_pkg::CFG_TOTAL_LENGTH:   total_length_reg   <= cfg_data;
                rapc_pkg::CFG_USED_LENGTH:    used_length_reg    <= cfg_data;
                rapc_pkg::CFG_MAX_TURNS:      max_turns_reg      <= cfg_data[TURN_W-1:0];
                rapc_pkg::CFG_TURN_DEADBAND:  turn_deadband_reg  <= cfg_data[DB_W-1:0];
                rapc_pkg::CFG_CALIBRATION_MS: calibration_ms_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Percent requests scale value by the used length; ticks scale the requested length
    // by the turn count over the full stroke.
    always_comb begin
        if (action == rapc_pkg::ACT_SET_PERCENT) begin
            mul_a = value_reg;
            mul_b = used_length_reg;
        end else begin
            mul_a = req_len_reg;
            mul_b = {{(LEN_W-TURN_W){1'b0}}, max_turns_reg};
        end
    end

    // The product of value and used length divided by 10000: drop the factor 16 by a
    // shift, then divide by 625 through its reciprocal.
    assign pct_num  = product_reg[PROD_W-1:rapc_pkg::PCT_PRE_SHIFT];
    assign pct_prod = {{rapc_pkg::PCT_RECIP_W{1'b0}}, pct_num}
                    * {{PCT_N_W{1'b0}}, rapc_pkg::PCT_RECIP};

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            action_reg <= s_data.action;
            value_reg  <= s_data.value;
        end
        if (cmd.mul_go) begin
            product_reg <= {{(PROD_W-LEN_W){1'b0}}, mul_a} * {{(PROD_W-LEN_W){1'b0}}, mul_b};
        end
        if (cmd.div_start) begin
            pct_quo_reg <= PROD_W'(pct_prod[PCT_P_W-1:rapc_pkg::PCT_RECIP_SHIFT]);
        end
    end

    // The percent quotient is ready in the cycle after the divide command.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pct_done_reg <= 1'b0;
        end else begin
            pct_done_reg <= cmd.div_start && (action == rapc_pkg::ACT_SET_PERCENT);
        end
    end

    assign div_start = cmd.div_start && (action != rapc_pkg::ACT_SET_PERCENT);

    // A zero total length makes every quotient bit one, which saturates the target.
    rapc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (product_reg),
        .divisor  (total_length_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    assign status.needs_div = (action == rapc_pkg::ACT_SET_PERCENT)
                           || ((action == rapc_pkg::ACT_TICK) && !cal_reg);
    assign status.div_done  = div_done || pct_done_reg;

    always_comb begin
        time_next       = time_reg;
        last_pulse_next = last_pulse_reg;
        cal_start_next  = cal_start_reg;
        cal_next        = cal_reg;
        mode_next       = mode_reg;
        turns_next      = turns_reg;
        req_len_next    = req_len_reg;
        target_next     = target_reg;

        tick_time   = time_reg + 1'b1;
        cal_elapsed = tick_time - cal_start_reg;
        pulse_gap   = time_reg - last_pulse_reg;
        quo_low     = quotient[LEN_W-1:0];
        target_sat  = (quotient[PROD_W-1:LEN_W] != '0) ? rapc_pkg::TARGET_MAX : quo_low;
        turns_wide  = {{(LEN_W-TURN_W){1'b0}}, turns_reg};

        unique case (mode_reg)
            rapc_pkg::DRIVE_EXTEND:  turns_step = {1'b0, turns_reg} + 1'b1;
            rapc_pkg::DRIVE_RETRACT: turns_step = (turns_reg != '0)
                                                ? {1'b0, turns_reg} - 1'b1
                                                : {1'b0, turns_reg};
            default:                 turns_step = {1'b0, turns_reg};
        endcase

        unique case (action)
            rapc_pkg::ACT_TICK: begin
                time_next = tick_time;
                if (cal_reg) begin
                    if (cal_elapsed > {{(TIME_W-LEN_W){1'b0}}, calibration_ms_reg}) begin
                        cal_next   = 1'b0;
                        turns_next = '0;
                    end
                end else begin
                    target_next = target_sat;
                    if ((target_sat > turns_wide) && ((target_sat - turns_wide)
                            > {{(LEN_W-DB_W){1'b0}}, turn_deadband_reg})) begin
                        mode_next = rapc_pkg::DRIVE_EXTEND;
                    end else if ((target_sat < turns_wide) && ((turns_wide - target_sat)
                            > {{(LEN_W-DB_W){1'b0}}, turn_deadband_reg})) begin
                        mode_next = rapc_pkg::DRIVE_RETRACT;
                    end else begin
                        mode_next = rapc_pkg::DRIVE_STOP;
                    end
                end
            end
            rapc_pkg::ACT_PULSE: begin
                if (pulse_gap > rapc_pkg::DEBOUNCE_MS) begin
                    last_pulse_next = time_reg;
                    if (turns_step > {1'b0, max_turns_reg}) begin
                        turns_next = max_turns_reg;
                    end else begin
                        turns_next = turns_step[TURN_W-1:0];
                    end
                end
            end
            rapc_pkg::ACT_SET_LENGTH: begin
                req_len_next = (value_reg < used_length_reg) ? value_reg : used_length_reg;
            end
            rapc_pkg::ACT_SET_PERCENT: begin
                req_len_next = (pct_quo_reg < {{(PROD_W-LEN_W){1'b0}}, used_length_reg})
                             ? pct_quo_reg[LEN_W-1:0] : used_length_reg;
            end
            rapc_pkg::ACT_CALIBRATE: begin
                if (!cal_reg) begin
                    cal_next       = 1'b1;
                    cal_start_next = time_reg;
                    mode_next      = rapc_pkg::DRIVE_RETRACT;
                end
            end
            rapc_pkg::ACT_SET_TURNS: begin
                turns_next = (value_reg > {{(LEN_W-TURN_W){1'b0}}, rapc_pkg::TURN_MAX})
                           ? rapc_pkg::TURN_MAX : value_reg[TURN_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg       <= '0;
            last_pulse_reg <= '0;
            cal_start_reg  <= '0;
            cal_reg        <= 1'b0;
            mode_reg       <= rapc_pkg::DRIVE_STOP;
            turns_reg      <= '0;
            req_len_reg    <= '0;
            target_reg     <= '0;
        end else if (cmd.commit) begin
            time_reg       <= time_next;
            last_pulse_reg <= last_pulse_next;
            cal_start_reg  <= cal_start_next;
            cal_reg        <= cal_next;
            mode_reg       <= mode_next;
            turns_reg      <= turns_next;
            req_len_reg    <= req_len_next;
            target_reg     <= target_next;
        end
    end

    // The state only changes at commit, which is also when a result is issued.
    assign m_data.drive_state         = mode_reg;
    assign m_data.extend_relay_level  = (mode_reg != rapc_pkg::DRIVE_EXTEND);
    assign m_data.retract_relay_level = (mode_reg != rapc_pkg::DRIVE_RETRACT);
    assign m_data.current_turns       = turns_reg;
    assign m_data.target_turns        = target_reg;
    assign m_data.calibrating         = cal_reg;

endmodule

`default_nettype wire

>>> design/relay_actuator_position_control.sv
// Top level: relay actuator position control, controller and datapath joined.
//
//   Port group   Direction  Beat contents
//   s_*          in         action code and 16-bit value
//   m_*          out        drive state, relay levels, turns, target, calibrating
//   cfg_*        in         register index and write data, no handshake
//
// Every accepted beat yields exactly one result beat. Ticks outside calibration pass
// through a 16 by 16 multiply followed by a 32-step restoring divider that retires one
// quotient bit per cycle. Percent requests take the same multiply, then a reciprocal
// multiply for the division by 10000. All other actions go from acceptance through the
// decode and commit states to the output. The block takes no new beat until the result
// of the last one is presented, so only one item is in the block at a time.
// Reset (aresetn low at a clock edge) restores the register defaults and clears all control state.
// A result waiting on m_ready does not stop the next beat from being taken; that beat
// holds in its commit step until the waiting result has been accepted.
`default_nettype none

module relay_actuator_position_control (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [rapc_pkg::CIDX_W-1:0] cfg_index,
    input  wire logic [rapc_pkg::CFG_W-1:0]  cfg_data,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire rapc_pkg::in_item_t          s_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output rapc_pkg::out_item_t              m_data
);

    // Commands flow from the controller to the datapath, status flows back.
    rapc_pkg::cmd_t    ctrl_cmd;
    rapc_pkg::status_t dp_status;

    // The controller owns the handshakes and decides when an item commits.
    rapc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (dp_status),
        .cmd     (ctrl_cmd)
    );

    // The datapath holds configuration, the control state and the arithmetic units.
    // Its state registers are shown directly on m_data.
    rapc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .m_data    (m_data),
        .cmd       (ctrl_cmd),
        .status    (dp_status)
    );

`ifndef ASSERT_OFF
    // State may only change while no earlier result is left waiting.
    a_commit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_cmd.commit |-> (!m_valid || m_ready))
        else $error("commit while a result is still waiting");

    // Every commit presents a result on the next cycle.
    a_commit_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_cmd.commit |=> m_valid)
        else $error("commit without a result beat");

    // Only one item is worked on at a time.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second beat taken while an item is in progress");

    // Calibration always runs with the actuator retracting.
    a_cal_retracts: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.calibrating) |-> (m_data.drive_state == rapc_pkg::DRIVE_RETRACT))
        else $error("calibration without retraction");
`endif

endmodule

`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench of the relay actuator position control block.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LEN_W  = rapc_pkg::LEN_W;
    localparam int unsigned TURN_W = rapc_pkg::TURN_W;
    localparam int unsigned DB_W   = rapc_pkg::DB_W;
    localparam int unsigned TIME_W = rapc_pkg::TIME_W;
    localparam int unsigned CIDX_W = rapc_pkg::CIDX_W;
    localparam int unsigned CFG_W  = rapc_pkg::CFG_W;

    // Action codes the block does not use. It must answer them with the unchanged status.
    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;

    localparam int unsigned PHASES          = 6;
    localparam int unsigned BEATS_PER_PHASE = 140;
    localparam int unsigned IDLE_PCT        = 38;
    localparam int unsigned LONG_HOLD       = 300;
    // This outlasts a whole tick, so it is enough to catch any stray result beat.
    localparam int unsigned DRAIN_CYCLES    = 80;
    // Calibrations are only started when the calibration time does not exceed CAL_LIMIT.
    localparam int unsigned CAL_LIMIT       = 1000;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CIDX_W-1:0]      cfg_index;
    logic [CFG_W-1:0]       cfg_data;
    logic                   s_valid;
    logic                   s_ready;
    rapc_pkg::in_item_t     s_data;
    logic                   m_valid;
    logic                   m_ready;
    rapc_pkg::out_item_t    m_data;

    relay_actuator_position_control DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // 4 ns period: two ns high, two ns low.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Mirror of the configuration registers.
    logic [LEN_W-1:0]  cfg_total;
    logic [LEN_W-1:0]  cfg_used;
    logic [TURN_W-1:0] cfg_turns;
    logic [DB_W-1:0]   cfg_db;
    logic [LEN_W-1:0]  cfg_cal;

    // Mirror of the controller state.
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] last_pulse_at;
    logic [TIME_W-1:0] cal_start_at;
    logic              cal_on;
    rapc_pkg::drive_t  mode;
    logic [TURN_W-1:0] turns;
    logic [LEN_W-1:0]  req_len;
    logic [LEN_W-1:0]  target;

    // Status beats that the block still owes us, oldest first.
    rapc_pkg::out_item_t reports_due[$];

    // One row of the directed opening sequence. Rows with typed set carry a status that
    // is obvious by hand; the others are checked against actuator_step.
    typedef struct {
        logic [2:0]          action;
        logic [LEN_W-1:0]    value;
        bit                  typed;
        rapc_pkg::out_item_t want;
    } beat_row_t;

    beat_row_t plan[$];

    int unsigned mismatches        = 0;
    int unsigned reports_seen      = 0;
    int unsigned beats_taken       = 0;
    int unsigned pulses_counted    = 0;
    int unsigned calibrations_done = 0;
    int unsigned long_stalls       = 0;

    // Traffic shaping shared by the sender and the receiver. quiet turns off all
    // random idling; hold_wanted asks the receiver for one long stall.
    bit          quiet       = 1'b0;
    bit          hold_wanted = 1'b0;
    int unsigned hold_left   = 0;

    function automatic bit idle_roll();
        return !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    function automatic logic [15:0] rand16();
        logic [31:0] w;
        w = $urandom;
        return w[15:0];
    endfunction

    function automatic void restore_defaults();
        cfg_total     = rapc_pkg::RST_TOTAL_LENGTH;
        cfg_used      = rapc_pkg::RST_USED_LENGTH;
        cfg_turns     = rapc_pkg::RST_MAX_TURNS;
        cfg_db        = rapc_pkg::RST_TURN_DEADBAND;
        cfg_cal       = rapc_pkg::RST_CALIBRATION_MS;
        now_ms        = '0;
        last_pulse_at = '0;
        cal_start_at  = '0;
        cal_on        = 1'b0;
        mode          = rapc_pkg::DRIVE_STOP;
        turns         = '0;
        req_len       = '0;
        target        = '0;
    endfunction

    function automatic void apply_register(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            rapc_pkg::CFG_TOTAL_LENGTH:   cfg_total = data;
            rapc_pkg::CFG_USED_LENGTH:    cfg_used  = data;
            rapc_pkg::CFG_MAX_TURNS:      cfg_turns = data[TURN_W-1:0];
            rapc_pkg::CFG_TURN_DEADBAND:  cfg_db    = data[DB_W-1:0];
            rapc_pkg::CFG_CALIBRATION_MS: cfg_cal   = data;
            default: ;
        endcase
    endfunction

    // Advances the mirrored controller by one accepted beat and returns the status
    // that the block must report for it.
    function automatic rapc_pkg::out_item_t actuator_step(rapc_pkg::in_item_t it);
        longint unsigned     quot;
        int unsigned         tg;
        int unsigned         tc;
        int unsigned         pct;
        rapc_pkg::out_item_t r;
        case (it.action)
            rapc_pkg::ACT_TICK: begin
                now_ms = now_ms + 32'd1;
                if (!cal_on) begin
                    // A zero stroke length and any quotient past 16 bits both pin the
                    // target at its maximum.
                    if (cfg_total == '0) begin
                        target = rapc_pkg::TARGET_MAX;
                    end else begin
                        quot = (64'(req_len) * 64'(cfg_turns)) / 64'(cfg_total);
                        target = (quot > 64'(rapc_pkg::TARGET_MAX))
                               ? rapc_pkg::TARGET_MAX : quot[15:0];
                    end
                    tg = 32'(target);
                    tc = 32'(turns);
                    if (tg > tc && tg - tc > 32'(cfg_db)) begin
                        mode = rapc_pkg::DRIVE_EXTEND;
                    end else if (tg < tc && tc - tg > 32'(cfg_db)) begin
                        mode = rapc_pkg::DRIVE_RETRACT;
                    end else begin
                        mode = rapc_pkg::DRIVE_STOP;
                    end
                end else if (now_ms - cal_start_at > 32'(cfg_cal)) begin
                    // Calibration ends; the drive keeps retracting until the next tick.
                    cal_on = 1'b0;
                    turns  = '0;
                    calibrations_done++;
                end
            end
            rapc_pkg::ACT_PULSE: begin
                if (now_ms - last_pulse_at > rapc_pkg::DEBOUNCE_MS) begin
                    tc = 32'(turns);
                    if (mode == rapc_pkg::DRIVE_EXTEND) begin
                        tc = tc + 1;
                    end else if (mode == rapc_pkg::DRIVE_RETRACT && tc > 0) begin
                        tc = tc - 1;
                    end
                    // The clamp applies even when stopped.
                    if (tc > 32'(cfg_turns)) tc = 32'(cfg_turns);
                    turns = tc[TURN_W-1:0];
                    last_pulse_at = now_ms;
                    pulses_counted++;
                end
            end
            rapc_pkg::ACT_SET_LENGTH: begin
                req_len = (it.value < cfg_used) ? it.value : cfg_used;
            end
            rapc_pkg::ACT_SET_PERCENT: begin
                pct = (32'(it.value) * 32'(cfg_used)) / 32'(rapc_pkg::PERCENT_FULL);
                req_len = (pct < 32'(cfg_used)) ? pct[15:0] : cfg_used;
            end
            rapc_pkg::ACT_CALIBRATE: begin
                if (!cal_on) begin
                    cal_on       = 1'b1;
                    cal_start_at = now_ms;
                    mode         = rapc_pkg::DRIVE_RETRACT;
                end
            end
            rapc_pkg::ACT_SET_TURNS: begin
                turns = (it.value > 16'(rapc_pkg::TURN_MAX))
                      ? rapc_pkg::TURN_MAX : it.value[TURN_W-1:0];
            end
            default: ;
        endcase
        r.drive_state         = mode;
        r.extend_relay_level  = (mode != rapc_pkg::DRIVE_EXTEND);
        r.retract_relay_level = (mode != rapc_pkg::DRIVE_RETRACT);
        r.current_turns       = turns;
        r.target_turns        = target;
        r.calibrating         = cal_on;
        return r;
    endfunction

    function automatic void add_row(logic [2:0] act, logic [15:0] val, bit typed,
                                    rapc_pkg::out_item_t want);
        beat_row_t row;
        row.action = act;
        row.value  = val;
        row.typed  = typed;
        row.want   = want;
        plan.push_back(row);
    endfunction

    function automatic void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_report(rapc_pkg::out_item_t got);
        rapc_pkg::out_item_t want;
        if (reports_due.size() == 0) begin
            $display("%0t ns: unexpected result beat, expected none, got %h", $time, got);
            mismatches++;
        end else begin
            want = reports_due.pop_front();
            compare_field("drive_state", 32'(want.drive_state), 32'(got.drive_state));
            compare_field("extend_relay_level", 32'(want.extend_relay_level),
                          32'(got.extend_relay_level));
            compare_field("retract_relay_level", 32'(want.retract_relay_level),
                          32'(got.retract_relay_level));
            compare_field("current_turns", 32'(want.current_turns), 32'(got.current_turns));
            compare_field("target_turns", 32'(want.target_turns), 32'(got.target_turns));
            compare_field("calibrating", 32'(want.calibrating), 32'(got.calibrating));
            reports_seen++;
        end
    endfunction

    // Register write through the plain write port. The enable is left high; the caller
    // lowers it once its batch of writes is done, so it never toggles within one step.
    task automatic write_register(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        apply_register(idx, data);
    endtask

    // Offers one beat on the input channel, after a random number of idle cycles, and
    // records what the block owes for it once it has been accepted. Every call starts
    // and ends right after a rising edge; s_valid stays high into the next call.
    task automatic push_beat(input logic [2:0] act, input logic [15:0] val, input bit typed,
                             input rapc_pkg::out_item_t want);
        rapc_pkg::in_item_t  it;
        rapc_pkg::out_item_t predicted;
        it.action = act;
        it.value  = val;
        while (idle_roll()) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = actuator_step(it);
        reports_due.push_back(typed ? want : predicted);
        beats_taken++;
    endtask

    task automatic drain_reports();
        while (reports_due.size() != 0) @(posedge aclk);
    endtask

    // Result side. Each rising edge first checks a beat that was accepted at that edge,
    // then decides m_ready for the next one. A requested long stall is counted here in
    // cycles, while the sender keeps offering beats and the block backs up.
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) check_report(m_data);
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (hold_wanted) begin
                hold_wanted = 1'b0;
                hold_left   = LONG_HOLD;
                long_stalls++;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !idle_roll();
            end
        end
    end

    // Watchdog. It ends the run as a failure if a correct run, with idling and stalls
    // included, would have finished long before.
    initial begin
        #4_000_000;
        $display("FAIL relay_actuator_position_control");
        $finish;
    end

    // Main sequence: reset, directed opening, then random phases under different
    // register settings, each phase started only once the block has gone idle.
    initial begin
        int unsigned phase;
        int unsigned counted;
        int unsigned n;
        int unsigned r;
        logic [15:0] tot;
        logic [15:0] used;
        logic [15:0] mt;
        logic [15:0] db;
        logic [15:0] cal;

        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        restore_defaults();

        // Directed opening with the reset register values: stroke 10000, usable 10000,
        // 100 turns, deadband 1, calibration 10000 ms.
        add_row(rapc_pkg::ACT_TICK, 16'd0, 1'b1,
                {rapc_pkg::DRIVE_STOP, 1'b1, 1'b1, 12'd0, 16'd0, 1'b0});
        // An oversized length is clamped to the usable stroke.
        add_row(rapc_pkg::ACT_SET_LENGTH, 16'hFFFF, 1'b1,
                {rapc_pkg::DRIVE_STOP, 1'b1, 1'b1, 12'd0, 16'd0, 1'b0});
        add_row(rapc_pkg::ACT_TICK, 16'hFFFF, 1'b1,
                {rapc_pkg::DRIVE_EXTEND, 1'b0, 1'b1, 12'd0, 16'd100, 1'b0});
        // Too soon after the last pulse, so it is dropped.
        add_row(rapc_pkg::ACT_PULSE, 16'hA5A5, 1'b1,
                {rapc_pkg::DRIVE_EXTEND, 1'b0, 1'b1, 12'd0, 16'd100, 1'b0});
        // Turn count saturates at 4095, above max_turns as well.
        add_row(rapc_pkg::ACT_SET_TURNS, 16'hFFFF, 1'b1,
                {rapc_pkg::DRIVE_EXTEND, 1'b0, 1'b1, 12'd4095, 16'd100, 1'b0});
        add_row(rapc_pkg::ACT_TICK, 16'h5A5A, 1'b1,
                {rapc_pkg::DRIVE_RETRACT, 1'b1, 1'b0, 12'd4095, 16'd100, 1'b0});
        add_row(ACT_SPARE_6, 16'hFFFF, 1'b1,
                {rapc_pkg::DRIVE_RETRACT, 1'b1, 1'b0, 12'd4095, 16'd100, 1'b0});
        add_row(ACT_SPARE_7, 16'h0000, 1'b1,
                {rapc_pkg::DRIVE_RETRACT, 1'b1, 1'b0, 12'd4095, 16'd100, 1'b0});
        // Percent above 100 saturates, then half the stroke.
        add_row(rapc_pkg::ACT_SET_PERCENT, 16'hFFFF, 1'b0, '0);
        add_row(rapc_pkg::ACT_SET_PERCENT, 16'd5000, 1'b0, '0);
        add_row(rapc_pkg::ACT_SET_TURNS, 16'd0, 1'b0, '0);
        add_row(rapc_pkg::ACT_TICK, 16'd0, 1'b0, '0);
        add_row(rapc_pkg::ACT_CALIBRATE, 16'd0, 1'b1,
                {rapc_pkg::DRIVE_RETRACT, 1'b1, 1'b0, 12'd0, 16'd50, 1'b1});
        // A second calibrate while one runs is ignored.
        add_row(rapc_pkg::ACT_CALIBRATE, 16'hFFFF, 1'b1,
                {rapc_pkg::DRIVE_RETRACT, 1'b1, 1'b0, 12'd0, 16'd50, 1'b1});
        add_row(rapc_pkg::ACT_SET_TURNS, 16'd30, 1'b0, '0);
        repeat (7) add_row(rapc_pkg::ACT_TICK, 16'd0, 1'b0, '0);
        // Now past the debounce window: a retracting pulse takes one turn off.
        add_row(rapc_pkg::ACT_PULSE, 16'd0, 1'b0, '0);
        add_row(rapc_pkg::ACT_SET_LENGTH, 16'd0, 1'b0, '0);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) push_beat(plan[i].action, plan[i].value, plan[i].typed, plan[i].want);

        for (phase = 0; phase < PHASES; phase++) begin
            s_valid <= 1'b0;
            drain_reports();

            // Settings run from the reset values through both extremes, a zero stroke
            // length and a short stroke whose target overflows 16 bits.
            case (phase)
                0: begin
                    tot = 16'd10000; used = 16'd10000; mt = 16'd100;
                    db  = 16'd1;     cal  = 16'd20;
                end
                1: begin
                    tot = 16'd65535; used = 16'd65535; mt = 16'd4095;
                    db  = 16'd255;   cal  = 16'd65535;
                end
                2: begin
                    tot = 16'd1;     used = 16'd0;     mt = 16'd1;
                    db  = 16'd0;     cal  = 16'd0;
                end
                3: begin
                    tot = 16'd0;     used = 16'd5000;  mt = 16'd200;
                    db  = 16'd3;     cal  = 16'd5;
                end
                4: begin
                    tot = 16'd300;   used = 16'd65535; mt = 16'd4095;
                    db  = 16'd2;     cal  = 16'd30;
                end
                default: begin
                    tot = 16'd10000; used = 16'd8000;  mt = 16'd50;
                    db  = 16'd0;     cal  = 16'd15;
                end
            endcase
            write_register(rapc_pkg::CFG_TOTAL_LENGTH, tot);
            write_register(rapc_pkg::CFG_USED_LENGTH, used);
            write_register(rapc_pkg::CFG_MAX_TURNS, mt);
            write_register(rapc_pkg::CFG_TURN_DEADBAND, db);
            write_register(rapc_pkg::CFG_CALIBRATION_MS, cal);
            cfg_wr_en <= 1'b0;

            // Phase 1 carries the long output stall; phase 2 runs without any idling.
            quiet       = (phase == 2);
            hold_wanted = (phase == 1);

            counted = 0;
            while (counted < BEATS_PER_PHASE) begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    // The usual shape: a run of ticks, then a Hall pulse, so that many
                    // pulses clear the debounce window and move the count.
                    n = $urandom_range(1, 14);
                    repeat (n) push_beat(rapc_pkg::ACT_TICK, rand16(), 1'b0, '0);
                    push_beat(rapc_pkg::ACT_PULSE, rand16(), 1'b0, '0);
                    counted += n + 1;
                end else if (r < 71) begin
                    push_beat(rapc_pkg::ACT_SET_LENGTH, $urandom_range(0, 1) ? rand16()
                              : 16'($urandom_range(0, 32'(cfg_used))), 1'b0, '0);
                    counted++;
                end else if (r < 77) begin
                    push_beat(rapc_pkg::ACT_SET_PERCENT, $urandom_range(0, 1) ? rand16()
                              : 16'($urandom_range(0, 32'(rapc_pkg::PERCENT_FULL))),
                              1'b0, '0);
                    counted++;
                end else if (r < 81) begin
                    push_beat(rapc_pkg::ACT_SET_TURNS, $urandom_range(0, 1) ? rand16()
                              : 16'($urandom_range(0, 32'(cfg_turns) + 2)), 1'b0, '0);
                    counted++;
                end else if (r < 86) begin
                    if (32'(cfg_cal) <= CAL_LIMIT) begin
                        push_beat(rapc_pkg::ACT_CALIBRATE, rand16(), 1'b0, '0);
                    end else begin
                        push_beat(rapc_pkg::ACT_TICK, rand16(), 1'b0, '0);
                    end
                    counted++;
                end else if (r < 92) begin
                    // Pulse bursts: mostly bounce that must be filtered.
                    n = $urandom_range(2, 4);
                    repeat (n) push_beat(rapc_pkg::ACT_PULSE, rand16(), 1'b0, '0);
                    counted += n;
                end else if (r < 95) begin
                    // Unused codes are not counted toward the phase.
                    push_beat($urandom_range(0, 1) ? ACT_SPARE_6 : ACT_SPARE_7, rand16(),
                              1'b0, '0);
                end else begin
                    // A long run of ticks lets the position settle and calibration end.
                    n = $urandom_range(15, 40);
                    repeat (n) push_beat(rapc_pkg::ACT_TICK, rand16(), 1'b0, '0);
                    counted += n;
                end
            end

            // Let a short calibration finish so that it does not freeze the next phase.
            while (cal_on && 32'(cfg_cal) <= CAL_LIMIT) begin
                push_beat(rapc_pkg::ACT_TICK, rand16(), 1'b0, '0);
            end
        end

        s_valid <= 1'b0;
        drain_reports();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d beats over a directed opening and %0d register settings,",
                 beats_taken, PHASES);
        $display("with %0d status beats checked, %0d pulses counted, %0d calibrations done.",
                 reports_seen, pulses_counted, calibrations_done);
        if (mismatches == 0 && reports_due.size() == 0) begin
            $display("PASS relay_actuator_position_control");
        end else begin
            $display("FAIL relay_actuator_position_control");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
design/rapc_pkg.sv
design/rapc_div.sv
design/rapc_ctrl.sv
design/rapc_dp.sv
design/relay_actuator_position_control.sv
verif/testbench.sv
